@@ sv/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the PI clock-rate servo.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;
   localparam int DIV_W      = 20;

   // reset values of the control registers
   localparam logic [19:0] PROP_DIV_RST  = 20'd10;
   localparam logic [19:0] INTEG_DIV_RST = 20'd1000;
   localparam logic [29:0] MAX_OFS_RST   = 30'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_DIV   = 3'd0,
      CSR_INTEG_DIV  = 3'd1,
      CSR_MAX_OFFSET = 3'd2,
      CSR_ADJ_DIS    = 3'd3,
      CSR_STEP_DIS   = 3'd4
   } prs_csr_type;

   typedef enum logic [1:0] {
      ACT_REJECT = 2'd0,
      ACT_HOLD   = 2'd1,
      ACT_STEP   = 2'd2,
      ACT_RATE   = 2'd3
   } prs_action_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted item
      logic div_start;   // start a quotient
      logic div_prop;    // divisor select: 1 proportional, 0 integral
      logic take_integ;  // store integral quotient
      logic take_prop;   // store proportional quotient
      logic commit;      // update state and load the result register
   } prs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pi_path;     // held item goes through PI control
      logic div_done;    // quotient ready this cycle
      logic out_free;    // result register may be loaded
   } prs_sts_type;

endpackage

@@ sv/prs_divider.sv @@
// ----------------------------------------------------------------------------
// prs_divider
// Unsigned radix-4 restoring divider, 32-bit dividend by 20-bit divisor,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
module prs_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [prs_pkg::DIV_W-1:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import prs_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [31:0]      quo_ff, quo_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0]   r1, r2, d1, d2;
   logic [DIV_W-1:0] rem1, rem2;
   logic             qb1, qb0;

   always_comb begin
      r1   = {rem_ff, quo_ff[31]};
      d1   = r1 - {1'b0, div_ff};
      qb1  = (r1 >= {1'b0, div_ff});
      rem1 = qb1 ? d1[DIV_W-1:0] : r1[DIV_W-1:0];
      r2   = {rem1, quo_ff[30]};
      d2   = r2 - {1'b0, div_ff};
      qb0  = (r2 >= {1'b0, div_ff});
      rem2 = qb0 ? d2[DIV_W-1:0] : r2[DIV_W-1:0];
   end

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem2;
         quo_in = {quo_ff[29:0], qb1, qb0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // done is registered in the same step that writes the last quotient bits
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |-> ##17 done_ff)
      else $error("divider result not ready 16 cycles after start");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule

@@ sv/prs_datapath.sv @@
// ----------------------------------------------------------------------------
// prs_datapath
// Control registers, held item, drift and warning state, quotient
// registers, result register and the shared divider.
// ----------------------------------------------------------------------------
module prs_datapath #(
   parameter int MAX_RATE_ADJUST = 512000,
   parameter int DIVISOR_FLOOR   = 1,
   parameter int BASE_TICK       = 134217728
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [prs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [prs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [prs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  prs_pkg::prs_cmd_type           cmd,
   output prs_pkg::prs_sts_type           sts
);
   import prs_pkg::*;

   localparam logic signed [33:0] MAX_ADJ = 34'(MAX_RATE_ADJUST);
   localparam logic signed [33:0] BASE    = 34'(BASE_TICK);
   localparam logic [DIV_W-1:0]   FLOOR   = DIV_W'(DIVISOR_FLOOR);

   // control registers
   logic [DIV_W-1:0] prop_ff, integ_ff;
   logic [29:0]      max_ofs_ff;
   logic             adj_dis_ff, step_dis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff     <= PROP_DIV_RST;
         integ_ff    <= INTEG_DIV_RST;
         max_ofs_ff  <= MAX_OFS_RST;
         adj_dis_ff  <= 1'b0;
         step_dis_ff <= 1'b0;
      end else if (csr_we) begin
         case (prs_csr_type'(csr_index))
            CSR_PROP_DIV:   prop_ff     <= csr_wdata[DIV_W-1:0];
            CSR_INTEG_DIV:  integ_ff    <= csr_wdata[DIV_W-1:0];
            CSR_MAX_OFFSET: max_ofs_ff  <= csr_wdata[29:0];
            CSR_ADJ_DIS:    adj_dis_ff  <= csr_wdata[0];
            CSR_STEP_DIS:   step_dis_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // held item
   logic signed [31:0] sec_ff;
   logic signed [30:0] ns_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sec_ff <= req_tdata[31:0];
         ns_ff  <= req_tdata[62:32];
      end
   end

   logic signed [31:0] ns_ext;
   logic [31:0]        ns_mag;
   logic               ns_neg, sec_nz, reject;

   always_comb begin
      ns_ext = {ns_ff[30], ns_ff};
      ns_neg = ns_ff[30];
      ns_mag = ns_neg ? 32'(-ns_ext) : 32'(ns_ext);
      sec_nz = (sec_ff != '0);
      reject = (max_ofs_ff != '0) &&
               (sec_nz || (ns_ext > $signed({2'b00, max_ofs_ff})));
   end

   // divider, with divisors floored
   logic [DIV_W-1:0] ap, ai;
   logic             div_done;
   logic [31:0]      quo;
   logic signed [31:0] quo_signed;

   assign ap = (prop_ff  < FLOOR) ? FLOOR : prop_ff;
   assign ai = (integ_ff < FLOOR) ? FLOOR : integ_ff;

   prs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ns_mag),
      .divisor  (cmd.div_prop ? ap : ai),
      .done     (div_done),
      .quotient (quo)
   );

   // truncation toward zero: negate magnitude quotient for negative offsets
   assign quo_signed = ns_neg ? $signed(-quo) : $signed(quo);

   logic signed [31:0] qi_ff, qp_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_integ) qi_ff <= quo_signed;
      if (cmd.take_prop)  qp_ff <= quo_signed;
   end

   // servo state
   logic signed [31:0] drift_ff, drift_in;
   logic               fast_ff, fast_in, slow_ff, slow_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   prs_action_type     act_ff, act_in;
   logic [31:0]        tick_ff, tick_in;
   logic [31:0]        ssec_ff, ssec_in;
   logic [30:0]        sns_ff, sns_in;

   logic signed [33:0] drift_sum, drift_clamp, adj_pi, adj_slew, tick_wide;

   always_comb begin
      drift_sum = {{2{drift_ff[31]}}, drift_ff} + {{2{qi_ff[31]}}, qi_ff};
      if (drift_sum > MAX_ADJ)
         drift_clamp = MAX_ADJ;
      else if (drift_sum < -MAX_ADJ)
         drift_clamp = -MAX_ADJ;
      else
         drift_clamp = drift_sum;
      adj_pi   = {{2{qp_ff[31]}}, qp_ff} + drift_clamp;
      adj_slew = (ns_ext > 0) ? MAX_ADJ : -MAX_ADJ;

      drift_in     = drift_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      act_in       = act_ff;
      tick_in      = tick_ff;
      ssec_in      = ssec_ff;
      sns_in       = sns_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      tick_wide    = '0;

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         tick_in      = '0;
         ssec_in      = '0;
         sns_in       = '0;
         if (reject) begin
            act_in = ACT_REJECT;
         end else if (sec_nz) begin
            if (adj_dis_ff) begin
               act_in = ACT_HOLD;
            end else if (!step_dis_ff) begin
               act_in   = ACT_STEP;
               tick_in  = BASE[31:0];
               drift_in = '0;
               ssec_in  = 32'(-sec_ff);
               sns_in   = 31'(-ns_ff);
            end else begin
               // slewing at full rate always raises both warnings
               act_in    = ACT_RATE;
               drift_in  = adj_slew[31:0];
               tick_wide = BASE - adj_slew;
               tick_in   = tick_wide[31:0];
               fast_in   = 1'b1;
               slow_in   = 1'b1;
            end
         end else begin
            drift_in = drift_clamp[31:0];
            if (adj_dis_ff) begin
               act_in = ACT_HOLD;
            end else begin
               act_in    = ACT_RATE;
               tick_wide = BASE - adj_pi;
               tick_in   = tick_wide[31:0];
               if (adj_pi >= MAX_ADJ || adj_pi <= -MAX_ADJ)
                  fast_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff     <= '0;
         fast_ff      <= 1'b0;
         slow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drift_ff     <= drift_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff  <= act_in;
      tick_ff <= tick_in;
      ssec_ff <= ssec_in;
      sns_ff  <= sns_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, slow_ff, fast_ff, drift_ff, sns_ff, ssec_ff, tick_ff, act_ff};

   assign sts.pi_path  = !reject && !sec_nz;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   a_drift_bound: assert property (@(posedge clock) disable iff (reset)
      ($signed({{2{drift_ff[31]}}, drift_ff}) <= MAX_ADJ) &&
      ($signed({{2{drift_ff[31]}}, drift_ff}) >= -MAX_ADJ))
      else $error("drift accumulator outside clamp range");

endmodule

@@ sv/prs_ctrl.sv @@
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer: accepts an item, runs the two quotients for PI control and
// commits the result once the result register is free.
// ----------------------------------------------------------------------------
module prs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output prs_pkg::prs_cmd_type  cmd,
   input  prs_pkg::prs_sts_type  sts
);
   import prs_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_DIV_I  = 5'b00100,
      ST_DIV_P  = 5'b01000,
      ST_FINISH = 5'b10000
   } prs_state_type;

   prs_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.pi_path) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_I;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_I: begin
            if (sts.div_done) begin
               cmd.take_integ = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_prop   = 1'b1;
               state_in       = ST_DIV_P;
            end
         end
         ST_DIV_P: begin
            cmd.div_prop = 1'b1;
            if (sts.div_done) begin
               cmd.take_prop = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("result committed over an untaken transfer");

endmodule

@@ sv/pi_clock_rate_servo.sv @@
// ----------------------------------------------------------------------------
// pi_clock_rate_servo
// PI clock-rate servo: offset from master in, clock action and tick rate out.
// ----------------------------------------------------------------------------
// One offset at a time. A rejected, stepped or slewed item, or a held-off one
// with nonzero seconds, skips the divider; any other item, held-off or not,
// goes through PI control on the shared two-bit-per-cycle divider, which works
// out the integral and then the proportional quotient. The next offset is
// taken as soon as the result is in the output register, even if that result
// has not yet been taken.
module pi_clock_rate_servo #(
   parameter int MAX_RATE_ADJUST = 512000,
   parameter int DIVISOR_FLOOR   = 1,
   parameter int BASE_TICK       = 134217728
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [prs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] offset_seconds, [62:32] offset_nanoseconds
   input  logic [prs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] action, [33:2] tick_rate, [65:34] step_seconds,
   // [96:66] step_nanoseconds, [128:97] drift_value,
   // [129] fast_slew_warned, [130] slow_slew_warned
   output logic [prs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import prs_pkg::*;

   prs_cmd_type cmd;
   prs_sts_type sts;

   prs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   prs_datapath #(
      .MAX_RATE_ADJUST (MAX_RATE_ADJUST),
      .DIVISOR_FLOOR   (DIVISOR_FLOOR),
      .BASE_TICK       (BASE_TICK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ bench/pi_clock_rate_servo_checker.sv @@
// ----------------------------------------------------------------------------
// pi_clock_rate_servo_checker
// Watches the CSR port and both streams of the PI clock-rate servo. It predicts
// each result from its own copy of the control registers, drift and warning
// flags, then compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module pi_clock_rate_servo_checker #(
   parameter int MAX_RATE_ADJUST = 512000,
   parameter int DIVISOR_FLOOR   = 1,
   parameter int BASE_TICK       = 134217728
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [prs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [31:0] offset_seconds, [62:32] offset_nanoseconds
   input  logic [prs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] action, [33:2] tick_rate, [65:34] step_seconds,
   // [96:66] step_nanoseconds, [128:97] drift_value,
   // [129] fast_slew_warned, [130] slow_slew_warned
   input  logic [prs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import prs_pkg::*;

   typedef struct packed {
      prs_action_type action;
      logic [31:0]    tick_rate;
      logic [31:0]    step_sec;
      logic [30:0]    step_ns;
      logic [31:0]    drift;
      logic           fast_warn;
      logic           slow_warn;
   } servo_outcome_type;

   // register copies
   logic [DIV_W-1:0] prop_div;
   logic [DIV_W-1:0] integ_div;
   logic [29:0]      max_ofs;
   logic             adj_dis;
   logic             step_dis;

   // servo state copies
   longint           drift_acc;
   logic             fast_warn;
   logic             slow_warn;

   servo_outcome_type outcome_q[$];

   function automatic servo_outcome_type predict_outcome(input logic [31:0] sec_bits,
                                                         input logic [30:0] ns_bits);
      longint            sec;
      longint            ns;
      longint            ap;
      longint            ai;
      longint            adj;
      servo_outcome_type r;
      sec = longint'($signed(sec_bits));
      ns  = longint'($signed(ns_bits));
      r   = '0;
      if (max_ofs != 0 && (sec != 0 || ns > longint'(max_ofs))) begin
         r.action = ACT_REJECT;
      end else if (sec != 0) begin
         if (adj_dis) begin
            r.action = ACT_HOLD;
         end else if (!step_dis) begin
            r.action    = ACT_STEP;
            r.tick_rate = 32'(BASE_TICK);
            r.step_sec  = -sec_bits;
            r.step_ns   = -ns_bits;
            drift_acc   = 0;
         end else begin
            // slew at full rate; first slew raises both warnings
            adj       = (ns > 0) ? longint'(MAX_RATE_ADJUST) : -longint'(MAX_RATE_ADJUST);
            drift_acc = adj;
            if (!slow_warn) begin
               slow_warn = 1'b1;
               fast_warn = 1'b1;
            end
            r.action    = ACT_RATE;
            r.tick_rate = 32'(longint'(BASE_TICK) - adj);
            if (adj >= MAX_RATE_ADJUST || adj <= -MAX_RATE_ADJUST) fast_warn = 1'b1;
         end
      end else begin
         ap = (longint'(prop_div) < DIVISOR_FLOOR) ? longint'(DIVISOR_FLOOR)
                                                   : longint'(prop_div);
         ai = (longint'(integ_div) < DIVISOR_FLOOR) ? longint'(DIVISOR_FLOOR)
                                                    : longint'(integ_div);
         drift_acc = drift_acc + ns / ai;
         if (drift_acc > MAX_RATE_ADJUST) drift_acc = MAX_RATE_ADJUST;
         else if (drift_acc < -MAX_RATE_ADJUST) drift_acc = -MAX_RATE_ADJUST;
         adj = ns / ap + drift_acc;
         // drift moves even when the clock may not be touched
         if (adj_dis) begin
            r.action = ACT_HOLD;
         end else begin
            r.action    = ACT_RATE;
            r.tick_rate = 32'(longint'(BASE_TICK) - adj);
            if (adj >= MAX_RATE_ADJUST || adj <= -MAX_RATE_ADJUST) fast_warn = 1'b1;
         end
      end
      r.drift     = 32'(drift_acc);
      r.fast_warn = fast_warn;
      r.slow_warn = slow_warn;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, actual 0x%08h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      servo_outcome_type want;
      servo_outcome_type got;
      if (reset) begin
         prop_div   = PROP_DIV_RST;
         integ_div  = INTEG_DIV_RST;
         max_ofs    = MAX_OFS_RST;
         adj_dis    = 1'b0;
         step_dis   = 1'b0;
         drift_acc  = 0;
         fast_warn  = 1'b0;
         slow_warn  = 1'b0;
         fail_count = 0;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROP_DIV:   prop_div  = csr_wdata[DIV_W-1:0];
               CSR_INTEG_DIV:  integ_div = csr_wdata[DIV_W-1:0];
               CSR_MAX_OFFSET: max_ofs   = csr_wdata[29:0];
               CSR_ADJ_DIS:    adj_dis   = csr_wdata[0];
               CSR_STEP_DIS:   step_dis  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(predict_outcome(req_tdata[31:0], req_tdata[62:32]));
         if (rsp_tvalid && rsp_tready) begin
            got.action    = prs_action_type'(rsp_tdata[1:0]);
            got.tick_rate = rsp_tdata[33:2];
            got.step_sec  = rsp_tdata[65:34];
            got.step_ns   = rsp_tdata[96:66];
            got.drift     = rsp_tdata[128:97];
            got.fast_warn = rsp_tdata[129];
            got.slow_warn = rsp_tdata[130];
            if (outcome_q.size() == 0) begin
               $error("result transfer with no offset outstanding");
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("action", 32'(want.action), 32'(got.action));
               check_field("tick_rate", want.tick_rate, got.tick_rate);
               check_field("step_seconds", want.step_sec, got.step_sec);
               check_field("step_nanoseconds", 32'(want.step_ns), 32'(got.step_ns));
               check_field("drift_value", want.drift, got.drift);
               check_field("fast_slew_warned", 32'(want.fast_warn), 32'(got.fast_warn));
               check_field("slow_slew_warned", 32'(want.slow_warn), 32'(got.slow_warn));
            end
         end
      end
      pending <= outcome_q.size();
   end

endmodule

@@ bench/pi_clock_rate_servo_tb.sv @@
// ----------------------------------------------------------------------------
// pi_clock_rate_servo_tb
// Stimulus and verdict for the PI clock-rate servo. A directed set of offsets
// covers rejection, hold-off, step, slew, PI clamping and wrap-around; random
// phases follow, each under its own register setting, with random gaps and
// stalls on both streams, one long output stall and drains between phases.
// ----------------------------------------------------------------------------
module pi_clock_rate_servo_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prs_pkg::*;

   localparam int MAX_RATE_ADJUST = 512000;
   localparam int DIVISOR_FLOOR   = 1;
   localparam int BASE_TICK       = 134217728;
   localparam int RUN_LIMIT       = 1000000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int PHASE_COUNT     = 13;
   localparam int PHASE_ITEMS     = 143;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int  fail_count;
   int  pending;
   int  cycle_count;
   bit  rsp_hold_req;
   bit  req_burst;
   bit  rsp_burst;
   logic [29:0] cur_max_ofs;

   pi_clock_rate_servo #(
      .MAX_RATE_ADJUST(MAX_RATE_ADJUST),
      .DIVISOR_FLOOR  (DIVISOR_FLOOR),
      .BASE_TICK      (BASE_TICK)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   pi_clock_rate_servo_checker #(
      .MAX_RATE_ADJUST(MAX_RATE_ADJUST),
      .DIVISOR_FLOOR  (DIVISOR_FLOOR),
      .BASE_TICK      (BASE_TICK)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one offset transfer, after a random gap (none while bursting)
   task automatic send_offset(input logic [31:0] sec, input logic [30:0] ns);
      int gap;
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, ns, sec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // sender stops until every outstanding result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_servo(input logic [19:0] prop, input logic [19:0] integ,
                            input logic [29:0] maxo, input logic adj,
                            input logic stp);
      csr_we    <= 1'b1;
      csr_index <= CSR_PROP_DIV;
      csr_wdata <= 30'(prop);
      @(posedge clock);
      csr_index <= CSR_INTEG_DIV;
      csr_wdata <= 30'(integ);
      @(posedge clock);
      csr_index <= CSR_MAX_OFFSET;
      csr_wdata <= maxo;
      @(posedge clock);
      csr_index <= CSR_ADJ_DIS;
      csr_wdata <= 30'(adj);
      @(posedge clock);
      csr_index <= CSR_STEP_DIS;
      csr_wdata <= 30'(stp);
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_max_ofs = maxo;
   endtask

   function automatic logic [19:0] pick_divisor();
      case ($urandom_range(0, 5))
         0: return 20'd0;
         1: return 20'd1;
         2: return 20'd10;
         3: return 20'd1000;
         4: return 20'd1000000;
         default: return 20'($urandom_range(0, 1000000));
      endcase
   endfunction

   task automatic run_random_phase(input int count);
      logic [31:0] sec;
      logic [30:0] ns;
      logic [29:0] maxo;
      int          v;
      case ($urandom_range(0, 7))
         0: maxo = 30'd1;
         1: maxo = 30'd999999999;
         2: maxo = 30'($urandom_range(1000, 999999999));
         3: maxo = 30'($urandom_range(1, 100000));
         default: maxo = 30'd0;
      endcase
      set_servo(pick_divisor(), pick_divisor(), maxo, $urandom_range(0, 4) == 0,
                1'($urandom_range(0, 1)));
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 20000)) - 10000;
            3, 4:    v = int'($urandom_range(0, 2000000)) - 1000000;
            5, 6:    v = int'($urandom_range(0, 1999999998)) - 999999999;
            7:       v = int'($urandom());
            8: begin
               case ($urandom_range(0, 6))
                  0: v = 0;
                  1: v = 1;
                  2: v = -1;
                  3: v = 999999999;
                  4: v = -999999999;
                  5: v = 32'h3FFF_FFFF;
                  default: v = -32'sh4000_0000;
               endcase
            end
            default: v = int'(cur_max_ofs) + int'($urandom_range(0, 2)) - 1;
         endcase
         ns = v[30:0];
         // mostly PI sequences so the drift gets to build up
         case ($urandom_range(0, 19))
            0, 1: sec = 32'(int'($urandom_range(1, 6)) - 3);
            2:    sec = $urandom();
            3:    sec = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: sec = 32'd0;
         endcase
         send_offset(sec, ns);
      end
      drain();
   endtask

   // result side: random stall per result, long hold-off on request
   initial begin
      int stall;
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      cur_max_ofs = MAX_OFS_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset settings: PI extremes with clamp, steps incl. most negative offset
      send_offset(32'd0, 31'd0);
      send_offset(32'd0, 31'd999999999);
      send_offset(32'd0, 31'(-999999999));
      send_offset(32'd0, 31'h3FFF_FFFF);
      send_offset(32'd0, 31'h3FFF_FFFF);
      send_offset(32'd0, 31'h4000_0000);
      send_offset(32'd1, 31'd5);
      send_offset(32'h8000_0000, 31'h4000_0000);
      send_offset(32'(-1), 31'(-7));
      drain();

      // slewing, then PI with floored divisors so the tick rate wraps
      set_servo(20'd0, 20'd0, 30'd0, 1'b0, 1'b1);
      send_offset(32'd5, 31'd100);
      send_offset(32'(-3), 31'(-100));
      send_offset(32'd2, 31'd0);
      send_offset(32'd0, 31'h3FFF_FFFF);
      send_offset(32'd0, 31'h4000_0000);
      drain();

      // tightest limit; large negative nanoseconds slip through; adjust off
      set_servo(20'd1000000, 20'd1000000, 30'd1, 1'b1, 1'b0);
      send_offset(32'd0, 31'd2);
      send_offset(32'd0, 31'd1);
      send_offset(32'd0, 31'(-999999999));
      send_offset(32'd1, 31'd0);
      drain();
      set_servo(20'd1, 20'd1, 30'd0, 1'b1, 1'b0);
      send_offset(32'd0, 31'd500);
      send_offset(32'd3, 31'd4);
      drain();

      // widest limit
      set_servo(20'd10, 20'd1000, 30'd999999999, 1'b0, 1'b0);
      send_offset(32'd0, 31'd999999999);
      send_offset(32'd0, 31'd1000000000);
      send_offset(32'd0, 31'h3FFF_FFFF);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 2) begin
            // output held off while offsets keep coming
            rsp_hold_req = 1'b1;
            req_burst    = 1'b1;
         end
         run_random_phase(PHASE_ITEMS);
      end

      repeat (64) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/prs_pkg.sv
sv/prs_divider.sv
sv/prs_datapath.sv
sv/prs_ctrl.sv
sv/pi_clock_rate_servo.sv
bench/pi_clock_rate_servo_checker.sv
bench/pi_clock_rate_servo_tb.sv
